// ----- src/idmh_pkg.sv -----
`default_nettype none
package idmh_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DELMIN = 2'd2,
    OP_REKEY  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DMIN1,
    S_DMIN2,
    S_TAKE0,
    S_TAKE1,
    S_TAKE2,
    S_RISE0,
    S_RISE1,
    S_RISE2,
    S_SINK0,
    S_SINK1,
    S_SINK2
  } state_t;

endpackage
`default_nettype wire

// ----- src/idmh_ram.sv -----
`default_nettype none
module idmh_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/indexed_dary_min_heap_core.sv -----
`default_nettype none
// Indexed d-ary min-heap over item numbers 1..MAX_ITEMS.
// Input channel: in_operation, in_item_id, in_key_value are taken on a rising
// edge with start high and busy low. Operations: insert, remove item,
// delete minimum and change key.
// Result channel: out_status, out_taken_item, out_taken_key, out_heap_count
// show for one cycle with out_valid high; the receiver cannot stall, and a
// new command may be started in the cycle the result is shown.
// Sequence: an empty delete minimum or an item number out of range shows its
// result in the cycle after the transfer; a failed presence check shows it
// after the extra S_CHECK state. An accepted one may then sift level by
// level: a sift-up reads the parent slot, then that item's key; a sift-down
// reads the first child slot, then for each child its slot and then its key.
// Each level takes these steps because each memory has a single read port:
// the slot read must return before the key of that item can be read.
// Reset: after rst_n the item-to-slot map is cleared one entry per cycle,
// entries 0 to MAX_ITEMS, with busy high; the heap is then empty.
module indexed_dary_min_heap_core #(
  parameter int MAX_ITEMS = 1024,
  parameter int ARITY     = 2,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_operation,
  input  wire logic [$clog2(MAX_ITEMS+1)-1:0]   in_item_id,
  input  wire logic [KEY_WIDTH-1:0]             in_key_value,
  output logic                                  out_valid,
  output logic [1:0]                            out_status,
  output logic [$clog2(MAX_ITEMS+1)-1:0]        out_taken_item,
  output logic [KEY_WIDTH-1:0]                  out_taken_key,
  output logic [$clog2(MAX_ITEMS+1)-1:0]        out_heap_count
);

  localparam int IW    = $clog2(MAX_ITEMS + 1);
  localparam int EW    = IW + 4;
  localparam int DEPTH = MAX_ITEMS + 1;

  localparam logic [IW-1:0] MAXI = IW'(MAX_ITEMS);
  localparam logic [EW-1:0] AR_E = EW'(ARITY);
  localparam logic [EW-1:0] AM2  = EW'(ARITY - 2);

  // parent slot by reciprocal multiplication, exact for every EW-bit value
  localparam int PSH   = EW + 3;
  localparam int RECIP = ((1 << PSH) + ARITY - 1) / ARITY;
  localparam logic [PSH-1:0] RCP = PSH'(RECIP);

  idmh_pkg::state_t state_r, state_nxt;

  logic [1:0]           op_r, op_nxt;
  logic [IW-1:0]        id_r, id_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [IW-1:0]        cnt_r, cnt_nxt;
  logic [IW-1:0]        it_r, it_nxt;
  logic [KEY_WIDTH-1:0] itkey_r, itkey_nxt;
  logic [IW-1:0]        x_r, x_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;
  logic [IW-1:0]        tgt_r, tgt_nxt;
  logic [KEY_WIDTH-1:0] tgtkey_r, tgtkey_nxt;
  logic [IW-1:0]        y_r, y_nxt;
  logic [IW-1:0]        best_r, best_nxt;
  logic [IW-1:0]        bitem_r, bitem_nxt;
  logic [KEY_WIDTH-1:0] bkey_r, bkey_nxt;
  logic [IW-1:0]        cand_r, cand_nxt;
  logic [IW-1:0]        clr_r, clr_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [IW-1:0]        titem_r, titem_nxt;
  logic [KEY_WIDTH-1:0] tkey_r, tkey_nxt;
  logic                 fin;

  // memory ports
  logic          hs_we, soi_we, key_we;
  logic [IW-1:0] hs_waddr, hs_wdata, hs_raddr, hs_rdata;
  logic [IW-1:0] soi_waddr, soi_wdata, soi_raddr, soi_rdata;
  logic [IW-1:0] key_waddr, key_raddr;
  logic [KEY_WIDTH-1:0] key_wdata, key_rdata;

  idmh_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_slots (
    .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
    .raddr(hs_raddr), .rdata(hs_rdata)
  );

  idmh_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_slot_of (
    .clk(clk), .we(soi_we), .waddr(soi_waddr), .wdata(soi_wdata),
    .raddr(soi_raddr), .rdata(soi_rdata)
  );

  idmh_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  // tree arithmetic on the current slot
  logic [EW-1:0] x_e, parent_e, kid1_e, kidn_e, cnt_e, y_e, ynext_e;
  logic [EW+PSH-1:0] parent_p;
  logic          is_kid1, kid_lt, more_kids;
  logic [IW-1:0] nb_slot, nb_item;
  logic [KEY_WIDTH-1:0] nb_key;

  assign x_e      = EW'(x_r);
  assign parent_p = {{PSH{1'b0}}, x_e + AM2} * {{EW{1'b0}}, RCP};
  assign parent_e = parent_p[EW+PSH-1:PSH];
  assign kid1_e   = AR_E * (x_e - EW'(1)) + EW'(2);
  assign kidn_e   = AR_E * x_e + EW'(1);
  assign cnt_e    = EW'(cnt_r);
  assign y_e      = EW'(y_r);
  assign ynext_e  = y_e + EW'(1);
  assign is_kid1  = (y_e == kid1_e);
  assign kid_lt   = key_rdata < bkey_r;
  assign more_kids = (ynext_e <= kidn_e) && (ynext_e <= cnt_e);
  assign nb_slot  = (is_kid1 || kid_lt) ? y_r : best_r;
  assign nb_item  = (is_kid1 || kid_lt) ? cand_r : bitem_r;
  assign nb_key   = (is_kid1 || kid_lt) ? key_rdata : bkey_r;

  assign busy = (state_r != idmh_pkg::S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= idmh_pkg::S_CLEAR;
      cnt_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    key_r    <= key_nxt;
    it_r     <= it_nxt;
    itkey_r  <= itkey_nxt;
    x_r      <= x_nxt;
    pos_r    <= pos_nxt;
    tgt_r    <= tgt_nxt;
    tgtkey_r <= tgtkey_nxt;
    y_r      <= y_nxt;
    best_r   <= best_nxt;
    bitem_r  <= bitem_nxt;
    bkey_r   <= bkey_nxt;
    cand_r   <= cand_nxt;
    status_r <= status_nxt;
    titem_r  <= titem_nxt;
    tkey_r   <= tkey_nxt;
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_status     <= status_nxt;
      out_taken_item <= titem_nxt;
      out_taken_key  <= tkey_nxt;
      out_heap_count <= cnt_nxt;
    end
  end

  // sequencer: next state, memory accesses
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    id_nxt     = id_r;
    key_nxt    = key_r;
    cnt_nxt    = cnt_r;
    it_nxt     = it_r;
    itkey_nxt  = itkey_r;
    x_nxt      = x_r;
    pos_nxt    = pos_r;
    tgt_nxt    = tgt_r;
    tgtkey_nxt = tgtkey_r;
    y_nxt      = y_r;
    best_nxt   = best_r;
    bitem_nxt  = bitem_r;
    bkey_nxt   = bkey_r;
    cand_nxt   = cand_r;
    clr_nxt    = clr_r;
    status_nxt = status_r;
    titem_nxt  = titem_r;
    tkey_nxt   = tkey_r;
    fin        = 1'b0;

    hs_we     = 1'b0;
    hs_waddr  = x_r;
    hs_wdata  = it_r;
    hs_raddr  = '0;
    soi_we    = 1'b0;
    soi_waddr = it_r;
    soi_wdata = x_r;
    soi_raddr = id_r;
    key_we    = 1'b0;
    key_waddr = id_r;
    key_wdata = key_r;
    key_raddr = id_r;

    unique case (state_r)
      // clear the item-to-slot map after reset
      idmh_pkg::S_CLEAR: begin
        soi_we    = 1'b1;
        soi_waddr = clr_r;
        soi_wdata = '0;
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == MAXI) begin
          state_nxt = idmh_pkg::S_IDLE;
        end
      end

      // command transfer
      idmh_pkg::S_IDLE: begin
        if (start) begin
          op_nxt     = in_operation;
          id_nxt     = in_item_id;
          key_nxt    = in_key_value;
          status_nxt = idmh_pkg::ST_DONE;
          titem_nxt  = '0;
          tkey_nxt   = '0;
          soi_raddr  = in_item_id;
          key_raddr  = in_item_id;
          hs_raddr   = IW'(1);
          if (in_operation == idmh_pkg::OP_DELMIN) begin
            if (cnt_r == '0) begin
              status_nxt = idmh_pkg::ST_EMPTY;
              fin        = 1'b1;
            end else begin
              state_nxt = idmh_pkg::S_DMIN1;
            end
          end else if (in_item_id == '0 || in_item_id > MAXI) begin
            status_nxt = idmh_pkg::ST_BAD;
            fin        = 1'b1;
          end else begin
            state_nxt = idmh_pkg::S_CHECK;
          end
        end
      end

      // presence check and old key
      idmh_pkg::S_CHECK: begin
        priority if (op_r == idmh_pkg::OP_INSERT) begin
          if (soi_rdata != '0) begin
            status_nxt = idmh_pkg::ST_BAD;
            fin        = 1'b1;
            state_nxt  = idmh_pkg::S_IDLE;
          end else begin
            key_we    = 1'b1;
            cnt_nxt   = cnt_r + IW'(1);
            it_nxt    = id_r;
            itkey_nxt = key_r;
            x_nxt     = cnt_r + IW'(1);
            state_nxt = idmh_pkg::S_RISE0;
          end
        end else if (soi_rdata == '0) begin
          status_nxt = idmh_pkg::ST_BAD;
          fin        = 1'b1;
          state_nxt  = idmh_pkg::S_IDLE;
        end else if (op_r == idmh_pkg::OP_REMOVE) begin
          tgt_nxt    = id_r;
          tgtkey_nxt = key_rdata;
          pos_nxt    = soi_rdata;
          state_nxt  = idmh_pkg::S_TAKE0;
        end else begin
          key_we    = 1'b1;
          it_nxt    = id_r;
          itkey_nxt = key_r;
          x_nxt     = soi_rdata;
          if (key_r < key_rdata) begin
            state_nxt = idmh_pkg::S_RISE0;
          end else if (key_r > key_rdata) begin
            state_nxt = idmh_pkg::S_SINK0;
          end else begin
            fin       = 1'b1;
            state_nxt = idmh_pkg::S_IDLE;
          end
        end
      end

      // delete minimum: top item, then its key
      idmh_pkg::S_DMIN1: begin
        titem_nxt = hs_rdata;
        tgt_nxt   = hs_rdata;
        key_raddr = hs_rdata;
        pos_nxt   = IW'(1);
        state_nxt = idmh_pkg::S_DMIN2;
      end

      idmh_pkg::S_DMIN2: begin
        tkey_nxt   = key_rdata;
        tgtkey_nxt = key_rdata;
        state_nxt  = idmh_pkg::S_TAKE0;
      end

      // removal: fetch the last item
      idmh_pkg::S_TAKE0: begin
        hs_raddr  = cnt_r;
        state_nxt = idmh_pkg::S_TAKE1;
      end

      idmh_pkg::S_TAKE1: begin
        cnt_nxt   = cnt_r - IW'(1);
        soi_we    = 1'b1;
        soi_waddr = tgt_r;
        soi_wdata = '0;
        it_nxt    = hs_rdata;
        x_nxt     = pos_r;
        key_raddr = hs_rdata;
        if (hs_rdata == tgt_r) begin
          fin       = 1'b1;
          state_nxt = idmh_pkg::S_IDLE;
        end else begin
          state_nxt = idmh_pkg::S_TAKE2;
        end
      end

      idmh_pkg::S_TAKE2: begin
        itkey_nxt = key_rdata;
        if (key_rdata <= tgtkey_r) begin
          state_nxt = idmh_pkg::S_RISE0;
        end else begin
          state_nxt = idmh_pkg::S_SINK0;
        end
      end

      // sift-up: parent slot
      idmh_pkg::S_RISE0: begin
        hs_raddr = parent_e[IW-1:0];
        if (x_r <= IW'(1)) begin
          hs_we     = 1'b1;
          soi_we    = 1'b1;
          fin       = 1'b1;
          state_nxt = idmh_pkg::S_IDLE;
        end else begin
          state_nxt = idmh_pkg::S_RISE1;
        end
      end

      idmh_pkg::S_RISE1: begin
        cand_nxt  = hs_rdata;
        key_raddr = hs_rdata;
        state_nxt = idmh_pkg::S_RISE2;
      end

      idmh_pkg::S_RISE2: begin
        hs_we  = 1'b1;
        soi_we = 1'b1;
        if (key_rdata > itkey_r) begin
          hs_wdata  = cand_r;
          soi_waddr = cand_r;
          x_nxt     = parent_e[IW-1:0];
          state_nxt = idmh_pkg::S_RISE0;
        end else begin
          fin       = 1'b1;
          state_nxt = idmh_pkg::S_IDLE;
        end
      end

      // sift-down: first child
      idmh_pkg::S_SINK0: begin
        hs_raddr = kid1_e[IW-1:0];
        y_nxt    = kid1_e[IW-1:0];
        if (kid1_e > cnt_e) begin
          hs_we     = 1'b1;
          soi_we    = 1'b1;
          fin       = 1'b1;
          state_nxt = idmh_pkg::S_IDLE;
        end else begin
          state_nxt = idmh_pkg::S_SINK1;
        end
      end

      idmh_pkg::S_SINK1: begin
        cand_nxt  = hs_rdata;
        key_raddr = hs_rdata;
        state_nxt = idmh_pkg::S_SINK2;
      end

      // fold in one child, then next child or move
      idmh_pkg::S_SINK2: begin
        best_nxt  = nb_slot;
        bitem_nxt = nb_item;
        bkey_nxt  = nb_key;
        hs_raddr  = ynext_e[IW-1:0];
        if (more_kids) begin
          y_nxt     = ynext_e[IW-1:0];
          state_nxt = idmh_pkg::S_SINK1;
        end else begin
          hs_we  = 1'b1;
          soi_we = 1'b1;
          if (nb_key < itkey_r) begin
            hs_wdata  = nb_item;
            soi_waddr = nb_item;
            x_nxt     = nb_slot;
            state_nxt = idmh_pkg::S_SINK0;
          end else begin
            fin       = 1'b1;
            state_nxt = idmh_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = idmh_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS = 1024;
  localparam int IW = 11;
  localparam int KW = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1030;

  typedef struct packed {
    idmh_pkg::status_t status;
    logic [IW-1:0]     item;
    logic [KW-1:0]     key;
    logic [IW-1:0]     count;
  } heap_result_t;

  typedef struct {
    idmh_pkg::op_t op;
    logic [IW-1:0] id;
    logic [KW-1:0] key;
    bit            typed;
    heap_result_t  res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = idmh_pkg::OP_DELMIN;
  logic [IW-1:0] in_item_id = '0;
  logic [KW-1:0] in_key_value = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [IW-1:0] out_taken_item;
  logic [KW-1:0] out_taken_key;
  logic [IW-1:0] out_heap_count;

  indexed_dary_min_heap_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_item_id(in_item_id), .in_key_value(in_key_value),
    .out_valid(out_valid), .out_status(out_status), .out_taken_item(out_taken_item),
    .out_taken_key(out_taken_key), .out_heap_count(out_heap_count)
  );

  always #5 clk = ~clk;

  // shadow heap state
  int unsigned   sh_slots [0:MAX_ITEMS];
  int unsigned   sh_slot_of [0:MAX_ITEMS];
  logic [KW-1:0] sh_keys [0:MAX_ITEMS];
  int unsigned   sh_count;

  heap_result_t expected_results [$];
  int errors = 0;
  int n_ops [4];
  int n_bad = 0, n_empty = 0, peak_count = 0, n_results = 0;

  // values as they stand just before the next rising edge
  logic take_s, valid_s;
  heap_result_t seen_s;
  always @(negedge clk) begin
    take_s <= start && !busy && rst_n;
    valid_s <= out_valid && rst_n;
    seen_s <= '{idmh_pkg::status_t'(out_status), out_taken_item, out_taken_key,
                out_heap_count};
  end

  task automatic put_item(int unsigned it, int unsigned x);
    sh_slots[x] = it;
    sh_slot_of[it] = x;
  endtask

  task automatic sift_up(int unsigned it, int unsigned x);
    int unsigned px;
    while (x > 1) begin
      px = x / 2;
      if (!(sh_keys[sh_slots[px]] > sh_keys[it])) break;
      put_item(sh_slots[px], x);
      x = px;
    end
    put_item(it, x);
  endtask

  function automatic int unsigned smallest_child(int unsigned x);
    int unsigned best;
    if (2 * x > sh_count) return 0;
    best = 2 * x;
    if (best + 1 <= sh_count && sh_keys[sh_slots[best + 1]] < sh_keys[sh_slots[best]])
      best = best + 1;
    return best;
  endfunction

  task automatic sift_down(int unsigned it, int unsigned x);
    int unsigned c;
    c = smallest_child(x);
    while (c != 0 && sh_keys[sh_slots[c]] < sh_keys[it]) begin
      put_item(sh_slots[c], x);
      x = c;
      c = smallest_child(x);
    end
    put_item(it, x);
  endtask

  task automatic pull_item(int unsigned it);
    int unsigned last, x;
    last = sh_slots[sh_count];
    x = sh_slot_of[it];
    sh_count--;
    if (last != it) begin
      if (sh_keys[last] <= sh_keys[it]) sift_up(last, x);
      else sift_down(last, x);
    end
    sh_slot_of[it] = 0;
  endtask

  // apply one command to the shadow heap and return its result
  task automatic predict_heap_op(input idmh_pkg::op_t op, input logic [IW-1:0] id,
                                 input logic [KW-1:0] key, output heap_result_t r);
    int unsigned it, top;
    logic [KW-1:0] old;
    r = '{idmh_pkg::ST_DONE, '0, '0, '0};
    it = 32'(id);
    if (op == idmh_pkg::OP_DELMIN) begin
      if (sh_count == 0) r.status = idmh_pkg::ST_EMPTY;
      else begin
        top = sh_slots[1];
        r.item = IW'(top);
        r.key = sh_keys[top];
        pull_item(top);
      end
    end else if (it == 0 || it > MAX_ITEMS) r.status = idmh_pkg::ST_BAD;
    else if (op == idmh_pkg::OP_INSERT) begin
      if (sh_slot_of[it] != 0) r.status = idmh_pkg::ST_BAD;
      else begin
        sh_keys[it] = key;
        sh_count++;
        sift_up(it, sh_count);
      end
    end else if (sh_slot_of[it] == 0) r.status = idmh_pkg::ST_BAD;
    else if (op == idmh_pkg::OP_REMOVE) pull_item(it);
    else begin
      old = sh_keys[it];
      sh_keys[it] = key;
      if (key < old) sift_up(it, sh_slot_of[it]);
      else if (key > old) sift_down(it, sh_slot_of[it]);
    end
    r.count = IW'(sh_count);
  endtask

  // drive one command and hold it until the transfer happens
  task automatic send_cmd(idmh_pkg::op_t op, logic [IW-1:0] id, logic [KW-1:0] key,
                          bit typed, heap_result_t typed_res, bit allow_gap);
    heap_result_t r;
    start <= 1'b1;
    in_operation <= op;
    in_item_id <= id;
    in_key_value <= key;
    do @(posedge clk); while (!take_s);
    predict_heap_op(op, id, key, r);
    expected_results.push_back(typed ? typed_res : r);
    n_ops[op]++;
    if (sh_count > peak_count) peak_count = sh_count;
    if (allow_gap && $urandom_range(99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(99) < 70 ? $urandom_range(1, 4) : $urandom_range(5, 70))
        @(posedge clk);
    end
  endtask

  // result check against oldest expectation
  always @(posedge clk) begin
    heap_result_t e;
    if (valid_s) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting: status %0d", seen_s.status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (seen_s.status == idmh_pkg::ST_BAD) n_bad++;
        if (seen_s.status == idmh_pkg::ST_EMPTY) n_empty++;
        if (seen_s.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, seen_s.status); errors++;
        end
        if (seen_s.item !== e.item) begin
          $error("taken_item expected %0d actual %0d", e.item, seen_s.item); errors++;
        end
        if (seen_s.key !== e.key) begin
          $error("taken_key expected %0h actual %0h", e.key, seen_s.key); errors++;
        end
        if (seen_s.count !== e.count) begin
          $error("heap_count expected %0d actual %0d", e.count, seen_s.count); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (take_s || valid_s) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("indexed_dary_min_heap_core regression: fail");
      $finish;
    end
  end

  function automatic logic [IW-1:0] pick_item(int unsigned pool);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return IW'($urandom_range(2047, 1025));
    if (r < 7) return '0;
    if (r < 80 && sh_count > 0) return IW'(sh_slots[$urandom_range(sh_count, 1)]);
    return IW'($urandom_range(pool, 1));
  endfunction

  function automatic logic [KW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return $urandom;
    if (r < 80 || sh_count == 0) return $urandom_range(15);
    return sh_keys[sh_slots[$urandom_range(sh_count, 1)]];
  endfunction

  stim_row_t rows [$];

  task automatic add_row(idmh_pkg::op_t op, int id, logic [KW-1:0] key, bit typed,
                         idmh_pkg::status_t st = idmh_pkg::ST_DONE, int it = 0,
                         logic [KW-1:0] k = '0, int cnt = 0);
    stim_row_t s;
    s.op = op; s.id = IW'(id); s.key = key; s.typed = typed;
    s.res = '{st, it[IW-1:0], k, cnt[IW-1:0]};
    rows.push_back(s);
  endtask

  initial begin
    int unsigned pool, ins_w, r;
    idmh_pkg::op_t op;
    logic [IW-1:0] nid;
    for (int i = 0; i <= MAX_ITEMS; i++) begin
      sh_slots[i] = 0; sh_slot_of[i] = 0; sh_keys[i] = '0;
    end
    sh_count = 0;
    foreach (n_ops[i]) n_ops[i] = 0;

    // directed: extremes, bad requests, ties, empty heap
    add_row(idmh_pkg::OP_DELMIN, 0, 0, 1, idmh_pkg::ST_EMPTY, 0, 0, 0);
    add_row(idmh_pkg::OP_INSERT, 0, 32'h1234, 1, idmh_pkg::ST_BAD, 0, 0, 0);
    add_row(idmh_pkg::OP_INSERT, 1025, 32'h1, 1, idmh_pkg::ST_BAD, 0, 0, 0);
    add_row(idmh_pkg::OP_INSERT, 2047, 32'hffffffff, 1, idmh_pkg::ST_BAD, 0, 0, 0);
    add_row(idmh_pkg::OP_REMOVE, 5, 0, 1, idmh_pkg::ST_BAD, 0, 0, 0);
    add_row(idmh_pkg::OP_REKEY, 5, 32'h7, 1, idmh_pkg::ST_BAD, 0, 0, 0);
    add_row(idmh_pkg::OP_INSERT, 1024, 32'hffffffff, 1, idmh_pkg::ST_DONE, 0, 0, 1);
    add_row(idmh_pkg::OP_INSERT, 1, 32'h0, 1, idmh_pkg::ST_DONE, 0, 0, 2);
    add_row(idmh_pkg::OP_INSERT, 1, 32'h5, 1, idmh_pkg::ST_BAD, 0, 0, 2);
    add_row(idmh_pkg::OP_INSERT, 2, 32'h0, 1, idmh_pkg::ST_DONE, 0, 0, 3);
    add_row(idmh_pkg::OP_INSERT, 3, 32'h7, 0);
    add_row(idmh_pkg::OP_REKEY, 3, 32'h7, 0);
    add_row(idmh_pkg::OP_REKEY, 1024, 32'h1, 0);
    add_row(idmh_pkg::OP_REKEY, 2, 32'h9, 0);
    add_row(idmh_pkg::OP_REMOVE, 3, 0, 0);
    add_row(idmh_pkg::OP_REMOVE, 0, 0, 1, idmh_pkg::ST_BAD, 0, 0, 3);
    add_row(idmh_pkg::OP_DELMIN, 0, 0, 1, idmh_pkg::ST_DONE, 1, 0, 2);
    add_row(idmh_pkg::OP_DELMIN, 2047, 32'hffffffff, 0);
    add_row(idmh_pkg::OP_DELMIN, 0, 0, 0);
    add_row(idmh_pkg::OP_DELMIN, 0, 0, 1, idmh_pkg::ST_EMPTY, 0, 0, 0);
    add_row(idmh_pkg::OP_INSERT, 1023, 32'h55555555, 0);
    add_row(idmh_pkg::OP_INSERT, 682, 32'haaaaaaaa, 0);
    add_row(idmh_pkg::OP_REMOVE, 1023, 0, 0);
    add_row(idmh_pkg::OP_REMOVE, 682, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i])
      send_cmd(rows[i].op, rows[i].id, rows[i].key, rows[i].typed, rows[i].res, 1'b1);

    // hold off until the directed results have drained
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);

    // random: small churn, growth to a deep heap, then drain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < 300) begin pool = 40; ins_w = 40; end
      else if (n < 700) begin pool = MAX_ITEMS; ins_w = 70; end
      else begin pool = MAX_ITEMS; ins_w = 15; end
      r = $urandom_range(99);
      if (r < ins_w) op = idmh_pkg::OP_INSERT;
      else if (r < ins_w + (100 - ins_w) / 3) op = idmh_pkg::OP_DELMIN;
      else if (r < ins_w + 2 * (100 - ins_w) / 3) op = idmh_pkg::OP_REKEY;
      else op = idmh_pkg::OP_REMOVE;
      if (op == idmh_pkg::OP_INSERT && $urandom_range(99) < 70)
        nid = IW'($urandom_range(pool, 1));
      else
        nid = pick_item(pool);
      send_cmd(op, nid, pick_key(), 1'b0, '0, !(n >= 400 && n < 600));
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d inserts, %0d removes, %0d delete-min, %0d change-key",
             n_ops[idmh_pkg::OP_INSERT], n_ops[idmh_pkg::OP_REMOVE],
             n_ops[idmh_pkg::OP_DELMIN], n_ops[idmh_pkg::OP_REKEY]);
    $display("%0d results, %0d rejected, %0d empty, heap peaked at %0d items",
             n_results, n_bad, n_empty, peak_count);
    if (errors == 0 && expected_results.size() == 0)
      $display("indexed_dary_min_heap_core regression: pass");
    else
      $display("indexed_dary_min_heap_core regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
